@@ sv/rmq_pkg.sv @@
`default_nettype none
package rmq_pkg;

	localparam int CW       = 16;
	localparam int DFW      = 17;
	localparam int RTW      = 17;
	localparam int SQ_STEPS = 17;
	localparam int SQ_REMW  = 35;
	localparam int DV_STEPS = 16;
	localparam int DV_REMW  = 33;
	localparam int DV_LAT   = DV_STEPS + 2;

	localparam logic signed [18:0] QONE = 19'sd16384;

	localparam logic [1:0] SEL_X     = 2'd0;
	localparam logic [1:0] SEL_Y     = 2'd1;
	localparam logic [1:0] SEL_Z     = 2'd2;
	localparam logic [1:0] SEL_TRACE = 2'd3;

	typedef logic signed [CW-1:0]  coef_t;
	typedef logic signed [DFW-1:0] diff_t;
	typedef logic [RTW-1:0]        root_t;

endpackage
`default_nettype wire

@@ sv/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion, signed Q2.14 in and out. One matrix transfer can be taken
// every cycle while the output is not held; each result passes through the 17-stage
// square root, the 16-stage dividers and the staging around them. When the output
// transfer is held, the whole pipeline holds with it and s_tready drops.
`default_nettype none
module rotation_matrix_to_quaternion (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // qx qy qz qw
	output logic [0:0]        m_tuser   // clipped
);

	localparam int SQ  = rmq_pkg::SQ_STEPS;
	localparam int DL  = rmq_pkg::DV_LAT;
	localparam int LAT = 2 + SQ + 1 + DL + 1;
	localparam int SW  = rmq_pkg::SQ_REMW;

	logic           en;
	logic           v_q [0:LAT-1];

	assign en       = !v_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LAT; n++) v_q[n] <= 1'b0;
		end else if (en) begin
			v_q[0] <= s_tvalid;
			for (int n = 1; n < LAT; n++) v_q[n] <= v_q[n-1];
		end
	end

	// stage 1: trace and axis pick
	rmq_pkg::coef_t   a [0:8];
	logic [1:0]       sel;
	logic signed [17:0] trace;
	rmq_pkg::coef_t   dmax;

	always_comb begin
		for (int n = 0; n < 9; n++) a[n] = rmq_pkg::coef_t'(s_tdata[n*16 +: 16]);
		trace = 18'(a[0]) + 18'(a[4]) + 18'(a[8]);
		sel   = rmq_pkg::SEL_X;
		dmax  = a[0];
		if (a[4] > a[0]) begin
			sel  = rmq_pkg::SEL_Y;
			dmax = a[4];
		end
		if (a[8] > dmax) sel = rmq_pkg::SEL_Z;
		if (trace > 18'sd0) sel = rmq_pkg::SEL_TRACE;
	end

	rmq_pkg::coef_t     m_s1 [0:8];
	logic [1:0]         sel_s1;
	logic signed [17:0] trace_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 9; n++) m_s1[n] <= a[n];
			sel_s1   <= sel;
			trace_s1 <= trace;
		end
	end

	// stage 2: radicand and numerators
	logic signed [18:0] vt;
	rmq_pkg::diff_t     dn [0:2];

	always_comb begin
		case (sel_s1)
			rmq_pkg::SEL_X: begin
				vt    = 19'(m_s1[0]) - 19'(m_s1[4]) - 19'(m_s1[8]) + rmq_pkg::QONE;
				dn[0] = 17'(m_s1[5]) - 17'(m_s1[7]);
				dn[1] = 17'(m_s1[1]) + 17'(m_s1[3]);
				dn[2] = 17'(m_s1[2]) + 17'(m_s1[6]);
			end
			rmq_pkg::SEL_Y: begin
				vt    = 19'(m_s1[4]) - 19'(m_s1[8]) - 19'(m_s1[0]) + rmq_pkg::QONE;
				dn[0] = 17'(m_s1[6]) - 17'(m_s1[2]);
				dn[1] = 17'(m_s1[5]) + 17'(m_s1[7]);
				dn[2] = 17'(m_s1[3]) + 17'(m_s1[1]);
			end
			rmq_pkg::SEL_Z: begin
				vt    = 19'(m_s1[8]) - 19'(m_s1[0]) - 19'(m_s1[4]) + rmq_pkg::QONE;
				dn[0] = 17'(m_s1[1]) - 17'(m_s1[3]);
				dn[1] = 17'(m_s1[6]) + 17'(m_s1[2]);
				dn[2] = 17'(m_s1[7]) + 17'(m_s1[5]);
			end
			default: begin
				vt    = 19'(trace_s1) + rmq_pkg::QONE;
				dn[0] = 17'(m_s1[5]) - 17'(m_s1[7]);
				dn[1] = 17'(m_s1[6]) - 17'(m_s1[2]);
				dn[2] = 17'(m_s1[1]) - 17'(m_s1[3]);
			end
		endcase
	end

	logic [SW-1:0]        rem_s  [0:SQ];
	rmq_pkg::root_t       root_s [0:SQ];
	rmq_pkg::diff_t       d_s    [0:SQ][0:2];
	logic [1:0]           sel_s  [0:SQ];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= vt[18] ? '0 : (SW'(vt[16:0]) << 16);
			root_s[0] <= '0;
			for (int n = 0; n < 3; n++) d_s[0][n] <= dn[n];
			sel_s[0]  <= sel_s1;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
		localparam int B = SQ - k;
		logic [SW-1:0] trial;
		logic          ge;
		assign trial = (SW'(root_s[k-1]) << (B + 1)) + (SW'(1) << (2 * B));
		assign ge    = (rem_s[k-1] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (rem_s[k-1] - trial) : rem_s[k-1];
				root_s[k] <= root_s[k-1] | (ge ? (rmq_pkg::RTW'(1) << B) : '0);
				for (int n = 0; n < 3; n++) d_s[k][n] <= d_s[k-1][n];
				sel_s[k]  <= sel_s[k-1];
			end
		end
	end

	// round to nearest
	rmq_pkg::root_t rr;
	assign rr = root_s[SQ] + rmq_pkg::RTW'(rem_s[SQ] > SW'(root_s[SQ]));

	rmq_pkg::root_t r_rnd;
	rmq_pkg::coef_t rc_rnd;
	logic           rz_rnd;
	rmq_pkg::diff_t d_rnd [0:2];
	logic [1:0]     sel_rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			r_rnd   <= rr;
			rc_rnd  <= rmq_pkg::coef_t'((rr + rmq_pkg::RTW'(2)) >> 2);
			rz_rnd  <= (rr == '0);
			for (int n = 0; n < 3; n++) d_rnd[n] <= d_s[SQ][n];
			sel_rnd <= sel_s[SQ];
		end
	end

	rmq_pkg::coef_t lq    [0:2];
	logic           lclip [0:2];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		rmq_div_lane u_lane (
			.clk    (clk),
			.en     (en),
			.d      (d_rnd[l]),
			.r      (r_rnd),
			.q      (lq[l]),
			.clip   (lclip[l])
		);
	end

	rmq_pkg::coef_t rc_s  [0:DL-1];
	logic           rz_s  [0:DL-1];
	logic [1:0]     sl_s  [0:DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s[0] <= rc_rnd;
			rz_s[0] <= rz_rnd;
			sl_s[0] <= sel_rnd;
			for (int n = 1; n < DL; n++) begin
				rc_s[n] <= rc_s[n-1];
				rz_s[n] <= rz_s[n-1];
				sl_s[n] <= sl_s[n-1];
			end
		end
	end

	// output register: place components by axis
	rmq_pkg::coef_t qx_q, qy_q, qz_q, qw_q;
	logic           clip_q;

	always_ff @(posedge clk) begin
		if (en) begin
			clip_q <= rz_s[DL-1] | lclip[0] | lclip[1] | lclip[2];
			case (sl_s[DL-1])
				rmq_pkg::SEL_X: begin
					qx_q <= rc_s[DL-1];
					qy_q <= lq[1];
					qz_q <= lq[2];
					qw_q <= lq[0];
				end
				rmq_pkg::SEL_Y: begin
					qx_q <= lq[2];
					qy_q <= rc_s[DL-1];
					qz_q <= lq[1];
					qw_q <= lq[0];
				end
				rmq_pkg::SEL_Z: begin
					qx_q <= lq[1];
					qy_q <= lq[2];
					qz_q <= rc_s[DL-1];
					qw_q <= lq[0];
				end
				default: begin
					qx_q <= lq[0];
					qy_q <= lq[1];
					qz_q <= lq[2];
					qw_q <= rc_s[DL-1];
				end
			endcase
		end
	end

	assign m_tdata = {qw_q, qz_q, qy_q, qx_q};
	assign m_tuser = clip_q;

endmodule
`default_nettype wire

@@ sv/rmq_div_lane.sv @@
`default_nettype none
module rmq_div_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire rmq_pkg::diff_t d,
	input  wire rmq_pkg::root_t r,
	output rmq_pkg::coef_t      q,
	output logic                clip
);

	localparam int N = rmq_pkg::DV_STEPS;
	localparam int W = rmq_pkg::DV_REMW;

	logic [W-1:0]         rem_s  [0:N];
	rmq_pkg::root_t       r_s    [0:N];
	logic [N-1:0]         quo_s  [0:N];
	logic                 ovf_s  [0:N];
	logic                 neg_s  [0:N];
	logic                 dz_s   [0:N];
	logic                 rz_s   [0:N];

	logic [rmq_pkg::DFW-1:0] mag;
	logic [W-1:0]            num;

	always_comb begin
		mag = d[rmq_pkg::DFW-1] ? rmq_pkg::DFW'(-d) : rmq_pkg::DFW'(d);
		num = (W'(mag) << 14) + W'(r >> 1);
	end

	// numerator, rounding term and overflow check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			r_s[0]   <= r;
			quo_s[0] <= '0;
			ovf_s[0] <= (num >= (W'(r) << N));
			neg_s[0] <= d[rmq_pkg::DFW-1];
			dz_s[0]  <= (d == '0);
			rz_s[0]  <= (r == '0);
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= N; k++) begin : g_div
		localparam int B = N - k;
		logic [W-1:0] sub;
		logic         ge;
		assign sub = W'(r_s[k-1]) << B;
		assign ge  = (rem_s[k-1] >= sub);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (rem_s[k-1] - sub) : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (ge ? (N'(1) << B) : '0);
				r_s[k]   <= r_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
				dz_s[k]  <= dz_s[k-1];
				rz_s[k]  <= rz_s[k-1];
			end
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (rz_s[N]) begin
				clip <= 1'b1;
				if (dz_s[N])
					q <= '0;
				else if (neg_s[N])
					q <= 16'sh8000;
				else
					q <= 16'sh7fff;
			end else if (!neg_s[N]) begin
				if (ovf_s[N] || quo_s[N] > 16'd32767) begin
					q    <= 16'sh7fff;
					clip <= 1'b1;
				end else begin
					q    <= rmq_pkg::coef_t'(quo_s[N]);
					clip <= 1'b0;
				end
			end else begin
				if (ovf_s[N] || quo_s[N] > 16'd32768) begin
					q    <= 16'sh8000;
					clip <= 1'b1;
				end else begin
					q    <= rmq_pkg::coef_t'(-quo_s[N]);
					clip <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire
